// ===== rtl/wu_line_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wu_line_pkg
// Shared types and constants for the antialiased line rasterizer.
// ----------------------------------------------------------------------------
package wu_line_pkg;

    localparam int CANVAS_W = 32;
    localparam int CANVAS_H = 32;
    localparam int COORD_W  = 5;
    localparam int FRAC_W   = 16;
    localparam int COV_W    = 9;
    localparam int BITS_W   = 4;
    localparam int DIV_CNT_W = 5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIVIDE,
        ST_FIRST,
        ST_STEP,
        ST_PAIR,
        ST_MAIN,
        ST_END
    } wu_state_t;

    typedef enum logic [1:0] {
        KIND_FLAT,
        KIND_STEEP,
        KIND_SHALLOW
    } wu_kind_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;      // capture a new line
        logic setup;     // order endpoints and compute deltas
        logic div_start; // clear divider
        logic div_step;  // one restoring division step
        logic advance;   // step along major axis
        logic emit;      // present a pixel
        logic sel_pair;  // pixel is the paired one
        logic sel_end;   // pixel is the far endpoint
        logic sel_first; // pixel is the near endpoint
        logic is_last;   // pixel is the final one of the line
    } wu_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic     off_canvas;
        wu_kind_t kind;
        logic     div_done;
        logic     steps_done; // no interior steps remain
        logic     pair_ok;    // paired pixel lies on the canvas
        logic     out_free;   // output register can take a pixel
    } wu_status_t;

endpackage

// ===== rtl/wu_line_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wu_line_ctrl
// Sequencer that walks one line: setup, division, then pixel emission.
// ----------------------------------------------------------------------------
module wu_line_ctrl
    import wu_line_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  wu_status_t status,
    output wu_cmd_t    cmd
);

    wu_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                if (status.off_canvas)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (status.div_done || status.kind == KIND_FLAT)
                begin
                    state_next = ST_FIRST;
                end
            end
            ST_FIRST:
            begin
                if (status.out_free)
                begin
                    if (status.steps_done)
                    begin
                        state_next = (status.kind == KIND_FLAT) ? ST_IDLE : ST_END;
                    end
                    else
                    begin
                        state_next = ST_STEP;
                    end
                end
            end
            ST_STEP:
            begin
                if (status.kind == KIND_FLAT)
                begin
                    if (status.out_free)
                    begin
                        state_next = status.steps_done ? ST_IDLE : ST_STEP;
                    end
                end
                else
                begin
                    state_next = ST_PAIR;
                end
            end
            ST_PAIR:
            begin
                // The paired pixel is checked against the canvas after the step.
                if (!status.pair_ok || status.out_free)
                begin
                    state_next = ST_MAIN;
                end
            end
            ST_MAIN:
            begin
                if (status.out_free)
                begin
                    state_next = status.steps_done ? ST_END : ST_STEP;
                end
            end
            ST_END:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_SETUP:
            begin
                cmd.setup     = 1'b1;
                cmd.div_start = 1'b1;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
            end
            ST_FIRST:
            begin
                cmd.emit      = status.out_free;
                cmd.sel_first = 1'b1;
                cmd.is_last   = status.steps_done && status.kind == KIND_FLAT;
            end
            ST_STEP:
            begin
                // Flat lines emit directly here; sloped lines step the accumulator.
                if (status.kind == KIND_FLAT)
                begin
                    cmd.emit    = status.out_free;
                    cmd.advance = status.out_free;
                    cmd.is_last = status.steps_done;
                end
                else
                begin
                    cmd.advance = 1'b1;
                end
            end
            ST_PAIR:
            begin
                cmd.emit     = status.out_free && status.pair_ok;
                cmd.sel_pair = 1'b1;
            end
            ST_MAIN:
            begin
                cmd.emit = status.out_free;
            end
            ST_END:
            begin
                cmd.emit    = status.out_free;
                cmd.sel_end = 1'b1;
                cmd.is_last = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    property p_accept_only_idle;
        @(posedge clk) disable iff (!rst_n) cmd.load |-> state_reg == ST_IDLE;
    endproperty
    assert property (p_accept_only_idle) else $error("line accepted while busy");

    property p_end_is_last;
        @(posedge clk) disable iff (!rst_n) (cmd.emit && cmd.sel_end) |-> cmd.is_last;
    endproperty
    assert property (p_end_is_last) else $error("end pixel not marked last");

    property p_emit_needs_room;
        @(posedge clk) disable iff (!rst_n) cmd.emit |-> status.out_free;
    endproperty
    assert property (p_emit_needs_room) else $error("pixel emitted into full register");

endmodule

// ===== rtl/wu_line_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wu_line_dp
// Endpoint registers, serial divider, error accumulator and output register.
// ----------------------------------------------------------------------------
module wu_line_dp
    import wu_line_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  wu_cmd_t              cmd,
    output wu_status_t           status,
    input  logic [COORD_W-1:0]   x_start,
    input  logic [COORD_W-1:0]   y_start,
    input  logic [COORD_W-1:0]   x_end,
    input  logic [COORD_W-1:0]   y_end,
    input  logic [31:0]          line_color,
    input  logic [BITS_W-1:0]    bits_cfg,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [COORD_W-1:0]   pixel_x,
    output logic [COORD_W-1:0]   pixel_y,
    output logic [31:0]          pixel_color,
    output logic [COV_W-1:0]     coverage,
    output logic                 blend,
    output logic                 last
);

    logic [COORD_W-1:0] xa_reg, ya_reg, xb_reg, yb_reg;
    logic [31:0]        col_reg;
    logic [COORD_W-1:0] x0_reg, y0_reg, x1_reg, y1_reg;
    logic [COORD_W-1:0] cx_reg, cy_reg;
    logic               xneg_reg;
    logic [COORD_W-1:0] major_reg, cnt_reg;
    logic               diag_reg;
    wu_kind_t           kind_reg;
    logic               off_reg;
    logic [FRAC_W-1:0]  acc_reg;
    logic [FRAC_W-1:0]  quo_reg;
    logic [COORD_W:0]   rem_reg;
    logic [DIV_CNT_W-1:0] dcnt_reg;
    logic [3:0]         bits_reg;

    // Endpoint ordering and deltas, used in the setup cycle.
    logic               swap;
    logic [COORD_W-1:0] sx0, sy0, sx1, sy1, adx, ady;
    logic               sneg;
    always_comb
    begin
        swap = ya_reg > yb_reg;
        sx0  = swap ? xb_reg : xa_reg;
        sy0  = swap ? yb_reg : ya_reg;
        sx1  = swap ? xa_reg : xb_reg;
        sy1  = swap ? ya_reg : yb_reg;
        sneg = sx1 < sx0;
        adx  = sneg ? (sx0 - sx1) : (sx1 - sx0);
        ady  = sy1 - sy0;
    end

    // Restoring division step on (minor << 16) / major.
    logic [COORD_W+1:0] trial;
    logic [COORD_W+1:0] shifted;
    always_comb
    begin
        shifted = {rem_reg, quo_reg[FRAC_W-1]};
        trial   = shifted - {2'b00, major_reg};
    end

    logic [FRAC_W:0]    acc_sum;
    logic [FRAC_W-1:0]  wgt;
    logic [COV_W-1:0]   levels;
    logic [COORD_W:0]   px_w, py_w;
    logic [COORD_W-1:0] xstep;
    always_comb
    begin
        acc_sum = {1'b0, acc_reg} + {1'b0, quo_reg};
        levels  = COV_W'(1) << bits_reg;
        wgt     = acc_reg >> (FRAC_W - 32'(bits_reg));
        xstep   = xneg_reg ? cx_reg - 1'b1 : cx_reg + 1'b1;
        if (kind_reg == KIND_STEEP)
        begin
            px_w = xneg_reg ? {1'b0, cx_reg} - 1'b1 : {1'b0, cx_reg} + 1'b1;
            py_w = {1'b0, cy_reg};
        end
        else
        begin
            px_w = {1'b0, cx_reg};
            py_w = {1'b0, cy_reg} + 1'b1;
        end
    end

    logic pair_ok;
    assign pair_ok = !px_w[COORD_W] && !py_w[COORD_W];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            xa_reg  <= x_start;
            ya_reg  <= y_start;
            xb_reg  <= x_end;
            yb_reg  <= y_end;
            col_reg <= line_color;
            bits_reg <= (bits_cfg == 4'd0) ? 4'd1 : (bits_cfg > 4'd8) ? 4'd8 : bits_cfg;
            off_reg <= 1'b0;
        end
        if (cmd.setup)
        begin
            x0_reg   <= sx0;
            y0_reg   <= sy0;
            x1_reg   <= sx1;
            y1_reg   <= sy1;
            cx_reg   <= sx0;
            cy_reg   <= sy0;
            xneg_reg <= sneg;
            acc_reg  <= '0;
            if (ady == '0 || adx == '0 || adx == ady)
            begin
                kind_reg  <= KIND_FLAT;
                major_reg <= (ady == '0) ? adx : ady;
                cnt_reg   <= (ady == '0) ? adx : ady;
                diag_reg  <= adx != '0;
            end
            else if (ady > adx)
            begin
                kind_reg  <= KIND_STEEP;
                major_reg <= ady;
                cnt_reg   <= ady - 1'b1;
                diag_reg  <= 1'b0;
            end
            else
            begin
                kind_reg  <= KIND_SHALLOW;
                major_reg <= adx;
                cnt_reg   <= adx - 1'b1;
                diag_reg  <= 1'b0;
            end
        end
        if (cmd.div_start)
        begin
            rem_reg  <= '0;
            dcnt_reg <= '0;
            quo_reg  <= {ady > adx ? adx : ady, 11'd0};
        end
        else if (cmd.div_step)
        begin
            // Dividend bits shift out of quo_reg top while quotient bits enter low.
            dcnt_reg <= dcnt_reg + 1'b1;
            if (!trial[COORD_W+1])
            begin
                rem_reg <= trial[COORD_W:0];
                quo_reg <= {quo_reg[FRAC_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[COORD_W:0];
                quo_reg <= {quo_reg[FRAC_W-2:0], 1'b0};
            end
        end
        if (cmd.advance)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (kind_reg == KIND_FLAT)
            begin
                if (major_reg != y1_reg - y0_reg || y1_reg == y0_reg)
                begin
                    cx_reg <= xstep;
                end
                else
                begin
                    cy_reg <= cy_reg + 1'b1;
                    if (diag_reg)
                    begin
                        cx_reg <= xstep;
                    end
                end
            end
            else
            begin
                acc_reg <= acc_sum[FRAC_W-1:0];
                if (kind_reg == KIND_STEEP)
                begin
                    cy_reg <= cy_reg + 1'b1;
                    if (acc_sum[FRAC_W])
                    begin
                        cx_reg <= xstep;
                    end
                end
                else
                begin
                    cx_reg <= xstep;
                    if (acc_sum[FRAC_W])
                    begin
                        cy_reg <= cy_reg + 1'b1;
                    end
                end
            end
        end
    end

    // Dividend is minor<<16; loaded as minor<<11 so 21 steps produce 16 quotient bits.
    // The upper five quotient bits are always zero because minor < major.
    logic div_done;
    assign div_done = dcnt_reg == DIV_CNT_W'(FRAC_W + COORD_W - 1);

    logic out_valid_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            pixel_color <= col_reg;
            last        <= cmd.is_last;
            if (cmd.sel_first)
            begin
                pixel_x  <= x0_reg;
                pixel_y  <= y0_reg;
                coverage <= levels;
                blend    <= 1'b0;
            end
            else if (cmd.sel_end)
            begin
                pixel_x  <= x1_reg;
                pixel_y  <= y1_reg;
                coverage <= levels;
                blend    <= 1'b0;
            end
            else if (kind_reg == KIND_FLAT)
            begin
                pixel_x  <= (major_reg != y1_reg - y0_reg || y1_reg == y0_reg) ? xstep :
                            (diag_reg ? xstep : cx_reg);
                pixel_y  <= (major_reg != y1_reg - y0_reg || y1_reg == y0_reg) ? cy_reg :
                            cy_reg + 1'b1;
                coverage <= levels;
                blend    <= 1'b0;
            end
            else if (cmd.sel_pair)
            begin
                pixel_x  <= px_w[COORD_W-1:0];
                pixel_y  <= py_w[COORD_W-1:0];
                coverage <= COV_W'(wgt);
                blend    <= 1'b1;
            end
            else
            begin
                pixel_x  <= cx_reg;
                pixel_y  <= cy_reg;
                coverage <= levels - COV_W'(wgt);
                blend    <= 1'b1;
            end
        end
    end

    assign out_valid = out_valid_reg;

    always_comb
    begin
        status.off_canvas = off_reg;
        status.kind       = kind_reg;
        status.div_done   = div_done;
        status.steps_done = (cmd.sel_first || cmd.sel_end) ? (cnt_reg == '0)
                          : (kind_reg == KIND_FLAT) ? (cnt_reg == 5'd1) : (cnt_reg == '0);
        status.pair_ok    = pair_ok;
        status.out_free   = !out_valid_reg || out_ready;
    end

    property p_pair_weight_fits;
        @(posedge clk) disable iff (!rst_n)
            (cmd.emit && cmd.sel_pair) |-> (COV_W'(wgt) < levels);
    endproperty
    assert property (p_pair_weight_fits) else $error("coverage weight overflow");

    property p_emit_raises_valid;
        @(posedge clk) disable iff (!rst_n) cmd.emit |=> out_valid_reg;
    endproperty
    assert property (p_emit_raises_valid) else $error("emitted pixel not shown");

    property p_div_below_major;
        @(posedge clk) disable iff (!rst_n)
            (cmd.div_step && kind_reg != KIND_FLAT) |=> (rem_reg < {1'b0, major_reg});
    endproperty
    assert property (p_div_below_major) else $error("divider remainder out of range");

endmodule

// ===== rtl/wu_antialiased_line_rasterizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wu_antialiased_line_rasterizer
// Top level of the Wu antialiased line rasterizer.
// ----------------------------------------------------------------------------
// Usage: a line item enters on the s_axis channel (endpoints and color). The
// block emits the line's pixels, in walking order, on m_axis, with tlast set
// on the final pixel of the line. Coverage is in units of 1/2^intensity_bits;
// blend = 1 asks downstream to mix with the framebuffer. The intensity_bits
// register is written through the cfg channel; the user must write it only
// while idle, as the block does not enforce this. One line is handled at a
// time. After acceptance a setup state orders the endpoints, then a bit-serial
// restoring divider forms the 16-bit slope for sloped lines. Pixels then
// leave at up to one per cycle from a single output register; each interior
// step of a sloped line first passes through an accumulator update state
// that emits no pixel. When the receiver stalls, the output register holds
// its item and the walk pauses; nothing is lost.
// Reset returns to idle with intensity_bits at 8 and no pixel pending.
// Endpoints are 5-bit so they always lie on the 32 x 32 canvas.
// ----------------------------------------------------------------------------
module wu_antialiased_line_rasterizer
    import wu_line_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // x_start[4:0], y_start[9:5], x_end[14:10], y_end[19:15], line_color[51:20]
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // pixel_x[4:0], pixel_y[9:5], pixel_color[41:10], coverage[50:42]
    output logic [55:0] m_axis_tdata,
    // blend
    output logic        m_axis_tuser,
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data
);

    logic [BITS_W-1:0] bits_reg;
    wu_cmd_t           cmd;
    wu_status_t        status;
    logic [COORD_W-1:0] px, py;
    logic [31:0]        pcol;
    logic [COV_W-1:0]   cov;

    // The register is always writable; the user must make writes only while idle, as the block does not enforce this.
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg <= 4'd8;
        end
        else if (cfg_valid)
        begin
            bits_reg <= cfg_data;
        end
    end

    wu_line_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    wu_line_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .x_start     (s_axis_tdata[4:0]),
        .y_start     (s_axis_tdata[9:5]),
        .x_end       (s_axis_tdata[14:10]),
        .y_end       (s_axis_tdata[19:15]),
        .line_color  (s_axis_tdata[51:20]),
        .bits_cfg    (bits_reg),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .pixel_x     (px),
        .pixel_y     (py),
        .pixel_color (pcol),
        .coverage    (cov),
        .blend       (m_axis_tuser),
        .last        (m_axis_tlast)
    );

    assign m_axis_tdata = {5'd0, cov, pcol, py, px};

    property p_no_accept_while_out;
        @(posedge clk) disable iff (!rst_n)
            (s_axis_tvalid && s_axis_tready && m_axis_tvalid) |-> m_axis_tlast;
    endproperty
    assert property (p_no_accept_while_out) else $error("new line before last pixel");

    property p_last_ends_line;
        @(posedge clk) disable iff (!rst_n)
            (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |-> !s_axis_tready;
    endproperty
    assert property (p_last_ends_line) else $error("ready while line still open");

    property p_cov_range;
        @(posedge clk) disable iff (!rst_n)
            m_axis_tvalid |-> (cov <= 9'd256);
    endproperty
    assert property (p_cov_range) else $error("coverage out of range");

endmodule

// ===== tb/sv/wu_antialiased_line_rasterizer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wu_antialiased_line_rasterizer_tb
// Self-checking testbench for the antialiased line rasterizer.
// ----------------------------------------------------------------------------
// Lines are sent on the input stream and the expected pixel stream is worked
// out by a behavioral line walker kept in this file. Every pixel that leaves
// the block is compared with the oldest expected pixel. Both stream sides
// stall at random, and the intensity register is swept over its whole range.
// ----------------------------------------------------------------------------
module wu_antialiased_line_rasterizer_tb
    import wu_line_pkg::*;
();

    typedef struct packed {
        logic [4:0]  px;
        logic [4:0]  py;
        logic [31:0] color;
        logic [8:0]  cov;
        logic        blend;
        logic        last;
    } pixel_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [3:0]  cfg_data;

    // The block's view of the intensity register, kept by the testbench.
    logic [3:0]  coverage_bits;
    pixel_t      pixel_queue[$];
    int          error_count;
    int          pixel_count;
    int          line_count;
    int          stall_cycles;
    bit          quiet_mode;

    wu_antialiased_line_rasterizer u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Adds one pixel to the expected stream if it lies on the canvas. Coordinates
    // are kept signed because paired pixels may step one position off the edge.
    task automatic add_pixel(input int x, input int y, input logic [31:0] color,
                             input int cov, input logic blend);
        pixel_t p;
        if (x < 0 || x >= CANVAS_W || y < 0 || y >= CANVAS_H)
            return;
        p.px    = x[4:0];
        p.py    = y[4:0];
        p.color = color;
        p.cov   = cov[8:0];
        p.blend = blend;
        p.last  = 1'b0;
        pixel_queue.push_back(p);
    endtask

    // Walks one line as the rasterizer does and queues the pixels it emits.
    task automatic predict_line(input logic [4:0] xa, input logic [4:0] ya,
                                input logic [4:0] xb, input logic [4:0] yb,
                                input logic [31:0] color);
        int x0, y0, x1, y1, dx, dy, xdir, nbits, levels, w, first_idx;
        logic [31:0] acc, slope;
        x0 = xa; y0 = ya; x1 = xb; y1 = yb;
        nbits = coverage_bits;
        if (nbits < 1) nbits = 1;
        if (nbits > 8) nbits = 8;
        levels = 1 << nbits;
        first_idx = pixel_queue.size();
        // Run downward: swap so the first endpoint has the smaller row.
        if (y0 > y1)
        begin
            x0 = yb > ya ? xa : xb;
            y0 = yb; x0 = xb; y1 = ya; x1 = xa;
        end
        add_pixel(x0, y0, color, levels, 1'b0);
        dx = x1 - x0;
        xdir = 1;
        if (dx < 0)
        begin
            xdir = -1;
            dx = -dx;
        end
        dy = y1 - y0;
        if (dy == 0)
        begin
            while (dx != 0)
            begin
                dx--;
                x0 += xdir;
                add_pixel(x0, y0, color, levels, 1'b0);
            end
        end
        else if (dx == 0 || dx == dy)
        begin
            do
            begin
                if (dx != 0) x0 += xdir;
                y0++;
                add_pixel(x0, y0, color, levels, 1'b0);
                dy--;
            end while (dy != 0);
        end
        else
        begin
            acc = 0;
            if (dy > dx)
            begin
                slope = (dx << 16) / dy;
                dy--;
                while (dy != 0)
                begin
                    acc += slope;
                    if (acc > 32'd65535)
                    begin
                        acc &= 32'h0000_ffff;
                        x0 += xdir;
                    end
                    y0++;
                    w = acc >> (16 - nbits);
                    add_pixel(x0 + xdir, y0, color, w, 1'b1);
                    add_pixel(x0, y0, color, levels - w, 1'b1);
                    dy--;
                end
            end
            else
            begin
                slope = (dy << 16) / dx;
                dx--;
                while (dx != 0)
                begin
                    acc += slope;
                    if (acc > 32'd65535)
                    begin
                        acc &= 32'h0000_ffff;
                        y0++;
                    end
                    x0 += xdir;
                    w = acc >> (16 - nbits);
                    add_pixel(x0, y0 + 1, color, w, 1'b1);
                    add_pixel(x0, y0, color, levels - w, 1'b1);
                    dx--;
                end
            end
            add_pixel(x1, y1, color, levels, 1'b0);
        end
        if (pixel_queue.size() > first_idx)
            pixel_queue[pixel_queue.size() - 1].last = 1'b1;
    endtask

    // Sends one line item and queues its expected pixels on acceptance. The
    // valid stays up after acceptance and is only dropped for an idle burst
    // or a drain, so back-to-back items need a single assignment per edge.
    task automatic send_line(input logic [4:0] xa, input logic [4:0] ya,
                             input logic [4:0] xb, input logic [4:0] yb,
                             input logic [31:0] color);
        if (!quiet_mode && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, color, yb, xb, ya, xa};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_line(xa, ya, xb, yb, color);
        line_count++;
    endtask

    // Waits until every expected pixel has arrived, plus a short tail.
    task automatic drain_pixels();
        s_axis_tvalid <= 1'b0;
        while (pixel_queue.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_coverage_bits(input logic [3:0] value);
        drain_pixels();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        coverage_bits = value;
    endtask

    task automatic send_random_line();
        logic [4:0] xa, ya, xb, yb;
        xa = $urandom; ya = $urandom;
        // Mostly short lines, with some long ones and some special slopes.
        case ($urandom_range(0, 5))
            0:       begin xb = $urandom; yb = $urandom; end
            1:       begin xb = $urandom; yb = ya; end
            2:       begin xb = xa; yb = $urandom; end
            default: begin
                xb = xa + 5'($urandom_range(0, 12)) - 5'd6;
                yb = ya + 5'($urandom_range(0, 12)) - 5'd6;
            end
        endcase
        send_line(xa, ya, xb, yb, $urandom);
    endtask

    task automatic test_directed_shapes();
        send_line(5'd3, 5'd3, 5'd3, 5'd3, 32'hFFFF_FFFF);   // single point
        send_line(5'd0, 5'd0, 5'd31, 5'd0, 32'h0000_0000);  // full-width row
        send_line(5'd31, 5'd31, 5'd0, 5'd31, 32'h1234_5678);
        send_line(5'd0, 5'd31, 5'd0, 5'd0, 32'hA5A5_5A5A);  // vertical, upward
        send_line(5'd0, 5'd0, 5'd31, 5'd31, 32'h5A5A_A5A5); // diagonals
        send_line(5'd31, 5'd0, 5'd0, 5'd31, 32'hDEAD_BEEF);
        send_line(5'd0, 5'd0, 5'd31, 5'd30, 32'h0F0F_F0F0); // near-diagonal
        send_line(5'd0, 5'd0, 5'd30, 5'd31, 32'hF0F0_0F0F);
        send_line(5'd31, 5'd0, 5'd0, 5'd7, 32'h0000_00FF);  // shallow, leftward
        send_line(5'd31, 5'd31, 5'd29, 5'd0, 32'hFF00_0000); // steep, near the right edge
        send_line(5'd0, 5'd5, 5'd31, 5'd9, 32'h8000_0001);
        send_line(5'd2, 5'd31, 5'd5, 5'd3, 32'h7FFF_FFFE);
        send_line(5'd10, 5'd10, 5'd11, 5'd12, 32'hCAFE_F00D);
    endtask

    task automatic test_coverage_sweep();
        logic [3:0] setting;
        setting = 4'd0;
        repeat (16)
        begin
            write_coverage_bits(setting);
            repeat (6) send_random_line();
            setting++;
        end
        write_coverage_bits(4'd8);
    endtask

    task automatic test_random_lines(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 2)
            begin
                // Hold off the sender until the block has fully drained.
                drain_pixels();
                write_coverage_bits(4'($urandom_range(1, 8)));
            end
            send_random_line();
        end
    endtask

    // Receiver: stalls at random in bursts, switched off in the quiet part.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_cycles = 0;
        end
        else if (quiet_mode)
            m_axis_tready <= 1'b1;
        else if (stall_cycles > 0)
        begin
            stall_cycles--;
            m_axis_tready <= (stall_cycles == 0);
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_cycles = $urandom_range(1, 13);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // Checks every accepted pixel against the oldest expectation.
    always @(posedge clk)
    begin
        pixel_t want;
        pixel_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.px    = m_axis_tdata[4:0];
            got.py    = m_axis_tdata[9:5];
            got.color = m_axis_tdata[41:10];
            got.cov   = m_axis_tdata[50:42];
            got.blend = m_axis_tuser;
            got.last  = m_axis_tlast;
            pixel_count++;
            if (pixel_queue.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected pixel %h", $realtime, got);
            end
            else
            begin
                want = pixel_queue.pop_front();
                if (got !== want)
                begin
                    error_count++;
                    $display("%0t: pixel mismatch exp x=%0d y=%0d c=%h cov=%0d b=%b l=%b",
                             $realtime, want.px, want.py, want.color, want.cov,
                             want.blend, want.last);
                    $display("%0t:                got x=%0d y=%0d c=%h cov=%0d b=%b l=%b",
                             $realtime, got.px, got.py, got.color, got.cov,
                             got.blend, got.last);
                end
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        coverage_bits = 4'd8;
        error_count   = 0;
        pixel_count   = 0;
        line_count    = 0;
        quiet_mode    = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_shapes();
        test_coverage_sweep();
        test_random_lines(170);
        quiet_mode = 1'b1;
        test_random_lines(40);
        drain_pixels();

        $display("Sent %0d lines and checked %0d pixels over coverage widths 0 to 15.",
                 line_count, pixel_count);
        if (error_count == 0)
            $display("[wu_antialiased_line_rasterizer] OK");
        else
            $display("[wu_antialiased_line_rasterizer] ERROR");
        $finish;
    end

    // Worst case is roughly 320 lines, stretched by stalls.
    initial
    begin
        #20ms;
        $display("[wu_antialiased_line_rasterizer] ERROR");
        $finish;
    end

endmodule
